@@ rtl/cpr_pkg.sv @@
`default_nettype none

package cpr_pkg;

  localparam int ROW_W   = 64;
  localparam int RULE_W  = 8;
  localparam int SLOT_W  = 3;
  localparam int POS_W   = 4;
  localparam int ENTRY_W = 3;
  localparam int SCHED_W = 48;
  localparam int IDX_W   = 8;

  localparam logic [ROW_W-1:0]   RULE_TABLE_RESET  = 64'd6434347739082295070;
  localparam logic [SCHED_W-1:0] SCHED_TABLE_RESET = 48'd67805629697690;

  // Register indexes on the config channel
  localparam logic [IDX_W-1:0] REG_RULE_TABLE  = 8'd0;
  localparam logic [IDX_W-1:0] REG_SCHED_TABLE = 8'd1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic              load;
    logic              step;
    logic [RULE_W-1:0] rule;
  } ctrl_t;

endpackage

`default_nettype wire

@@ rtl/cpr_cell.sv @@
`default_nettype none

module cpr_cell
  import cpr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire ctrl_t ctrl,
  input  wire logic  seed_bit,
  input  wire logic  left,
  input  wire logic  right,
  output logic       q
);

  logic [2:0] nbhd;

  assign nbhd = {left, q, right};

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= 1'b0;
    end else if (ctrl.load) begin
      q <= seed_bit;
    end else if (ctrl.step) begin
      q <= ctrl.rule[nbhd];
    end
  end

endmodule

`default_nettype wire

@@ rtl/cpr_rule_seq.sv @@
`default_nettype none

module cpr_rule_seq
  import cpr_pkg::*;
#(
  parameter int SCHEDULE_LEN = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [ROW_W-1:0]   cfg_data,
  input  wire logic               item_load,
  input  wire logic               item_step,
  output ctrl_t                   ctrl
);

  logic [ROW_W-1:0]   rule_table;
  logic [SCHED_W-1:0] sched_table;
  logic [POS_W-1:0]   pos;
  logic [SLOT_W-1:0]  slot;
  logic [POS_W-1:0]   pos_next;
  logic [SLOT_W-1:0]  slot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_table  <= RULE_TABLE_RESET;
      sched_table <= SCHED_TABLE_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_RULE_TABLE:  rule_table  <= cfg_data;
        REG_SCHED_TABLE: sched_table <= cfg_data[SCHED_W-1:0];
        default: ;
      endcase
    end
  end

  // Next schedule position wraps after the last entry
  always_comb begin
    if (pos == POS_W'(SCHEDULE_LEN - 1)) begin
      pos_next = '0;
    end else begin
      pos_next = pos + POS_W'(1);
    end
    slot_next = slot + sched_table[ENTRY_W*pos_next +: ENTRY_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      slot <= SCHED_TABLE_RESET[ENTRY_W-1:0];
    end else if (item_load) begin
      pos  <= '0;
      slot <= sched_table[ENTRY_W-1:0];
    end else if (item_step) begin
      pos  <= pos_next;
      slot <= slot_next;
    end
  end

  assign ctrl.load = item_load;
  assign ctrl.step = item_step;
  assign ctrl.rule = rule_table[RULE_W*slot +: RULE_W];

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(SCHEDULE_LEN - 1))
    else $error("schedule position past last entry");

  a_load_restart: assert property (@(posedge clk) disable iff (rst)
    item_load |=> (pos == '0))
    else $error("load did not restart schedule");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (!item_load && !item_step) |=> ($stable(pos) && $stable(slot)))
    else $error("schedule moved without a transaction");
`endif

endmodule

`default_nettype wire

@@ rtl/ca_permuted_rule_keystream.sv @@
// A result is registered in the output register, or in the skid stage while
//   the output is stalled. One transaction per cycle while the skid stage is
//   empty; every cell updates in parallel from its stored bit and its two ring
//   neighbors, and the rule byte is chosen by the schedule sequencer in the same cycle.
// Reset (rst, synchronous, active high): row cleared, schedule position 0,
//   rule slot set to entry 0 of the default schedule, tables to their defaults.
`default_nettype none

module ca_permuted_rule_keystream
  import cpr_pkg::*;
#(
  parameter int CELL_COUNT   = 64,
  parameter int SCHEDULE_LEN = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input stream
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [ROW_W-1:0]   s_tdata,   // [63:0] seed
  input  wire logic               s_tuser,   // [0] opcode (0 load, 1 step)
  // Output stream
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [ROW_W-1:0]        m_tdata,   // [63:0] row
  // Config write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [ROW_W-1:0]   cfg_data
);

  logic                  s_acc;
  logic                  m_take;
  logic                  item_load;
  logic                  item_step;
  ctrl_t                 ctrl;
  logic [CELL_COUNT-1:0] row_q;
  logic [ROW_W-1:0]      result;

  // Skid stage behind the output register
  logic                  skid_valid;
  logic [ROW_W-1:0]      skid_data;

  assign cfg_ready = 1'b1;

  assign s_tready  = !skid_valid;
  assign s_acc     = s_tvalid && s_tready;
  assign m_take    = m_tvalid && m_tready;
  assign item_load = s_acc && (s_tuser == OP_LOAD);
  assign item_step = s_acc && (s_tuser == OP_STEP);

  cpr_rule_seq #(
    .SCHEDULE_LEN(SCHEDULE_LEN)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_load (item_load),
    .item_step (item_step),
    .ctrl      (ctrl)
  );

  // Ring of cells: left neighbor is i+1, right neighbor is i-1, both wrapping
  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    localparam int L = (i + 1) % CELL_COUNT;
    localparam int R = (i + CELL_COUNT - 1) % CELL_COUNT;
    cpr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .seed_bit (s_tdata[i]),
      .left     (row_q[L]),
      .right    (row_q[R]),
      .q        (row_q[i])
    );
  end

  // Load reports the (masked) seed; step reports the row before its update
  assign result = (s_tuser == OP_LOAD) ? ROW_W'(s_tdata[CELL_COUNT-1:0])
                                       : ROW_W'(row_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_take) begin
      m_tvalid   <= skid_valid || s_acc;
      skid_valid <= 1'b0;
    end else if (s_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_take) begin
      m_tdata <= skid_valid ? skid_data : result;
    end else if (s_acc) begin
      skid_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds data with output register empty");

  a_acc_gives_out: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> m_tvalid)
    else $error("accepted transaction produced no result");

  a_direct_data: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (!m_tvalid || m_take)) |=> (m_tdata == $past(result)))
    else $error("output register lost the result");

  a_step_loaded: assert property (@(posedge clk) disable iff (rst)
    item_load |=> (ROW_W'(row_q) == $past(ROW_W'(s_tdata[CELL_COUNT-1:0]))))
    else $error("cell row not loaded from seed");
`endif

endmodule

`default_nettype wire
